@@ hw/rtl/b3sh_pkg.sv @@
// ----------------------------------------------------------------------------
// b3sh_pkg
// Shared types, constants and the mixing function of the BLAKE3 stream hasher.
// ----------------------------------------------------------------------------
package b3sh_pkg;

  localparam int unsigned MaxTreeDepth = 54;
  localparam int unsigned InQueueDepth = 2;

  localparam logic [3:0] FlagStart  = 4'd1;
  localparam logic [3:0] FlagEnd    = 4'd2;
  localparam logic [3:0] FlagParent = 4'd4;
  localparam logic [3:0] FlagRoot   = 4'd8;

  localparam logic [6:0] BlockBytes = 7'd64;

  localparam logic [7:0][31:0] Iv = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam logic [15:0][3:0] MsgPerm = {
    4'd8, 4'd15, 4'd14, 4'd9, 4'd5, 4'd12, 4'd11, 4'd1,
    4'd13, 4'd4, 4'd0, 4'd7, 4'd10, 4'd3, 4'd6, 4'd2
  };

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        final_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        last_word;
  } out_item_t;

  // classified word as held between front and back
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        fin;
  } q_entry_t;

  typedef struct packed {
    logic [7:0][31:0]  cv;
    logic [15:0][31:0] blk;
    logic [63:0]       ctr;
    logic [6:0]        len;
    logic [3:0]        flags;
  } cmp_req_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } g_t;

  function automatic g_t g_fn(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, logic [31:0] x, logic [31:0] y);
    g_t r;
    r.a = a + b + x;
    r.d = d ^ r.a;
    r.d = {r.d[15:0], r.d[31:16]};
    r.c = c + r.d;
    r.b = b ^ r.c;
    r.b = {r.b[11:0], r.b[31:12]};
    r.a = r.a + r.b + y;
    r.d = r.d ^ r.a;
    r.d = {r.d[7:0], r.d[31:8]};
    r.c = r.c + r.d;
    r.b = r.b ^ r.c;
    r.b = {r.b[6:0], r.b[31:7]};
    return r;
  endfunction

endpackage

@@ hw/rtl/blake3_256_stream_hasher_core.sv @@
// ----------------------------------------------------------------------------
// blake3_256_stream_hasher_core
// A word within a block is absorbed at once; one on a full block waits for
// its compression, one on a full chunk for the chunk compression and subtree
// merges. Throughput is bound by the single compression core. Last word:
// fold compresses once per stack entry and once for the root; the digest
// then leaves as four words. Async reset returns the hasher to IV.
// ----------------------------------------------------------------------------
module blake3_256_stream_hasher_core #(
  parameter int unsigned MaxTreeDepth = b3sh_pkg::MaxTreeDepth,
  parameter int unsigned InQueueDepth = b3sh_pkg::InQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b3sh_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output b3sh_pkg::out_item_t out_item_o
);

  localparam int unsigned Aw = (MaxTreeDepth > 1) ? $clog2(MaxTreeDepth) : 1;
  localparam int unsigned Dw = $clog2(MaxTreeDepth + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_BLK    = 10'b00_0000_0010,
    S_CHUNK  = 10'b00_0000_0100,
    S_MCHK   = 10'b00_0000_1000,
    S_MRD    = 10'b00_0001_0000,
    S_MWAIT  = 10'b00_0010_0000,
    S_ABSORB = 10'b00_0100_0000,
    S_FOLD   = 10'b00_1000_0000,
    S_FWAIT  = 10'b01_0000_0000,
    S_ROOT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic               q_valid, q_take;
  b3sh_pkg::q_entry_t q_entry;
  b3sh_pkg::q_entry_t item_q, item_d;

  logic [7:0][31:0] cv_q, cv_d, tmp_q, tmp_d;
  logic [7:0][63:0] buf_q, buf_d;
  logic [6:0]       fill_q, fill_d;
  logic [3:0]       bd_q, bd_d;
  logic [63:0]      ci_q, ci_d, total_q, total_d;
  logic [Dw-1:0]    depth_q, depth_d, depth_m1;
  logic             first_q, first_d;

  logic               cmp_start, cmp_busy;
  b3sh_pkg::cmp_req_t cmp_req;
  logic [7:0][31:0]   cmp_res;

  logic          ram_we, ram_re;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [255:0]  ram_rdata;

  logic [255:0] dig_q, dig_d;
  logic         ov_q, ov_d;
  logic [1:0]   oidx_q, oidx_d;

  logic       chunk_full;
  logic [3:0] sflag;
  logic [63:0] masked;

  b3sh_in_queue #(.Depth(InQueueDepth)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item_i),
    .full_o  (full),
    .valid_o (q_valid),
    .take_i  (q_take),
    .entry_o (q_entry)
  );

  b3sh_compress u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmp_start),
    .req_i   (cmp_req),
    .busy_o  (cmp_busy),
    .res_o   (cmp_res)
  );

  b3sh_ram #(.Width(256), .Depth(MaxTreeDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tmp_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign chunk_full = (bd_q == 4'd15) && (fill_q == b3sh_pkg::BlockBytes);
  assign sflag      = (bd_q == 4'd0) ? b3sh_pkg::FlagStart : 4'd0;
  assign depth_m1   = depth_q - 1'b1;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < item_q.nbytes) ? item_q.data[8*b +: 8] : 8'd0;
    end
  end

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    cv_d      = cv_q;
    tmp_d     = tmp_q;
    buf_d     = buf_q;
    fill_d    = fill_q;
    bd_d      = bd_q;
    ci_d      = ci_q;
    total_d   = total_q;
    depth_d   = depth_q;
    first_d   = first_q;
    dig_d     = dig_q;
    ov_d      = ov_q;
    oidx_d    = oidx_q;
    q_take    = 1'b0;
    cmp_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = (depth_q >= Dw'(MaxTreeDepth)) ? Aw'(MaxTreeDepth - 1) : depth_q[Aw-1:0];
    ram_raddr = depth_m1[Aw-1:0];

    cmp_req.cv    = cv_q;
    cmp_req.blk   = buf_q;
    cmp_req.ctr   = ci_q;
    cmp_req.len   = fill_q;
    cmp_req.flags = sflag;

    if (!empty && pop) begin
      oidx_d = oidx_q + 1'b1;
      if (oidx_q == 2'd3) begin
        ov_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          item_d = q_entry;
          if (q_entry.nbytes != 4'd0 && chunk_full) begin
            cmp_req.flags = sflag | b3sh_pkg::FlagEnd;
            cmp_start     = 1'b1;
            total_d       = ci_q + 64'd1;
            state_d       = S_CHUNK;
          end else if (q_entry.nbytes != 4'd0 && fill_q == b3sh_pkg::BlockBytes) begin
            cmp_start = 1'b1;
            state_d   = S_BLK;
          end else begin
            state_d = S_ABSORB;
          end
        end
      end
      S_BLK: begin
        if (!cmp_busy) begin
          cv_d    = cmp_res;
          bd_d    = bd_q + 1'b1;
          buf_d   = '0;
          fill_d  = '0;
          state_d = S_ABSORB;
        end
      end
      S_CHUNK: begin
        if (!cmp_busy) begin
          tmp_d   = cmp_res;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        // merge while the new chunk count has a trailing zero
        if (!total_q[0] && depth_q != '0) begin
          ram_re  = 1'b1;
          depth_d = depth_m1;
          state_d = S_MRD;
        end else begin
          ram_we = 1'b1;
          if (depth_q < Dw'(MaxTreeDepth)) begin
            depth_d = depth_q + 1'b1;
          end
          cv_d    = b3sh_pkg::Iv;
          buf_d   = '0;
          fill_d  = '0;
          bd_d    = '0;
          // total_q has been shifted by the merges
          ci_d    = ci_q + 64'd1;
          state_d = S_ABSORB;
        end
      end
      S_MRD: begin
        cmp_req.cv    = b3sh_pkg::Iv;
        cmp_req.blk   = {tmp_q, ram_rdata};
        cmp_req.ctr   = '0;
        cmp_req.len   = b3sh_pkg::BlockBytes;
        cmp_req.flags = b3sh_pkg::FlagParent;
        cmp_start     = 1'b1;
        total_d       = {1'b0, total_q[63:1]};
        state_d       = S_MWAIT;
      end
      S_MWAIT: begin
        if (!cmp_busy) begin
          tmp_d   = cmp_res;
          state_d = S_MCHK;
        end
      end
      S_ABSORB: begin
        if (item_q.nbytes != 4'd0) begin
          buf_d[fill_q[5:3]] = buf_q[fill_q[5:3]] | masked;
          fill_d = fill_q + 7'(item_q.nbytes);
        end
        first_d = 1'b1;
        state_d = item_q.fin ? S_FOLD : S_IDLE;
      end
      S_FOLD: begin
        if (first_q) begin
          cmp_req.flags = sflag | b3sh_pkg::FlagEnd;
        end else begin
          cmp_req.cv    = b3sh_pkg::Iv;
          cmp_req.blk   = {tmp_q, ram_rdata};
          cmp_req.ctr   = '0;
          cmp_req.len   = b3sh_pkg::BlockBytes;
          cmp_req.flags = b3sh_pkg::FlagParent;
        end
        if (depth_q != '0) begin
          ram_re    = 1'b1;
          cmp_start = 1'b1;
          depth_d   = depth_m1;
          state_d   = S_FWAIT;
        end else if (!ov_q) begin
          cmp_req.ctr   = '0;
          cmp_req.flags = cmp_req.flags | b3sh_pkg::FlagRoot;
          cmp_start     = 1'b1;
          state_d       = S_ROOT;
        end
      end
      S_FWAIT: begin
        if (!cmp_busy) begin
          tmp_d   = cmp_res;
          first_d = 1'b0;
          state_d = S_FOLD;
        end
      end
      S_ROOT: begin
        if (!cmp_busy) begin
          dig_d   = cmp_res;
          ov_d    = 1'b1;
          oidx_d  = '0;
          cv_d    = b3sh_pkg::Iv;
          buf_d   = '0;
          fill_d  = '0;
          bd_d    = '0;
          ci_d    = '0;
          depth_d = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cv_q    <= b3sh_pkg::Iv;
      buf_q   <= '0;
      fill_q  <= '0;
      bd_q    <= '0;
      ci_q    <= '0;
      depth_q <= '0;
      first_q <= 1'b1;
      ov_q    <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cv_q    <= cv_d;
      buf_q   <= buf_d;
      fill_q  <= fill_d;
      bd_q    <= bd_d;
      ci_q    <= ci_d;
      depth_q <= depth_d;
      first_q <= first_d;
      ov_q    <= ov_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    tmp_q   <= tmp_d;
    total_q <= total_d;
    dig_q   <= dig_d;
  end

  assign empty                  = !ov_q;
  assign out_item_o.digest_word = dig_q[64*oidx_q +: 64];
  assign out_item_o.last_word   = (oidx_q == 2'd3);

  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= Dw'(MaxTreeDepth))
    else $error("subtree stack depth out of range");

  a_fill_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (fill_q[2:0] == 3'd0 && fill_q <= b3sh_pkg::BlockBytes))
    else $error("block fill misaligned between words");

  a_cmp_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_start |-> !cmp_busy)
    else $error("compression started while busy");

  a_digest_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && !cmp_busy) |-> !ov_q)
    else $error("digest overwritten before drained");

endmodule

@@ hw/rtl/b3sh_ram.sv @@
// ----------------------------------------------------------------------------
// b3sh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b3sh_ram #(
  parameter int unsigned Width = 256,
  parameter int unsigned Depth = 54,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/b3sh_in_queue.sv @@
// ----------------------------------------------------------------------------
// b3sh_in_queue
// Front end: takes input words, works out the byte count, queues them.
// ----------------------------------------------------------------------------
module b3sh_in_queue #(
  parameter int unsigned Depth = b3sh_pkg::InQueueDepth,
  localparam int unsigned Pw = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned Cw = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b3sh_pkg::in_item_t  item_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                take_i,
  output b3sh_pkg::q_entry_t  entry_o
);

  b3sh_pkg::q_entry_t slot_q [Depth];
  logic [Pw-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  b3sh_pkg::q_entry_t cls;
  logic do_push, do_take;

  // non-last words always carry eight bytes; counts above eight clamp
  always_comb begin
    cls.data = item_i.data_word;
    cls.fin  = item_i.final_item;
    if (!item_i.final_item || item_i.byte_count > 4'd8) begin
      cls.nbytes = 4'd8;
    end else begin
      cls.nbytes = item_i.byte_count;
    end
  end

  assign full_o  = (cnt_q == Cw'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_take = take_i && valid_o;
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == Pw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_take) begin
      rptr_d = (rptr_q == Pw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_take) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cls;
    end
  end

endmodule

@@ hw/rtl/b3sh_compress.sv @@
// ----------------------------------------------------------------------------
// b3sh_compress
// Compression core: one half round (four G mixes) per cycle.
// ----------------------------------------------------------------------------
module b3sh_compress (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  b3sh_pkg::cmp_req_t req_i,
  output logic               busy_o,
  output logic [7:0][31:0]   res_o
);

  logic [15:0][31:0] v_q, v_d, m_q, m_d;
  logic [3:0] step_q, step_d;
  logic busy_q, busy_d;
  b3sh_pkg::g_t g [4];

  always_comb begin
    v_d    = v_q;
    m_d    = m_q;
    step_d = step_q;
    busy_d = busy_q;
    for (int i = 0; i < 4; i++) begin
      g[i] = '0;
    end
    if (start_i) begin
      v_d[7:0]   = req_i.cv;
      v_d[11:8]  = b3sh_pkg::Iv[3:0];
      v_d[12]    = req_i.ctr[31:0];
      v_d[13]    = req_i.ctr[63:32];
      v_d[14]    = {25'd0, req_i.len};
      v_d[15]    = {28'd0, req_i.flags};
      m_d        = req_i.blk;
      step_d     = '0;
      busy_d     = 1'b1;
    end else if (busy_q) begin
      if (!step_q[0]) begin
        for (int i = 0; i < 4; i++) begin
          g[i] = b3sh_pkg::g_fn(v_q[i], v_q[4+i], v_q[8+i], v_q[12+i],
                                m_q[2*i], m_q[2*i+1]);
          v_d[i]    = g[i].a;
          v_d[4+i]  = g[i].b;
          v_d[8+i]  = g[i].c;
          v_d[12+i] = g[i].d;
        end
      end else begin
        // diagonals, then permute the message for the next round
        for (int i = 0; i < 4; i++) begin
          g[i] = b3sh_pkg::g_fn(v_q[i], v_q[4+((i+1)%4)], v_q[8+((i+2)%4)],
                                v_q[12+((i+3)%4)], m_q[8+2*i], m_q[9+2*i]);
          v_d[i]              = g[i].a;
          v_d[4+((i+1)%4)]    = g[i].b;
          v_d[8+((i+2)%4)]    = g[i].c;
          v_d[12+((i+3)%4)]   = g[i].d;
        end
        for (int i = 0; i < 16; i++) begin
          m_d[i] = m_q[b3sh_pkg::MsgPerm[i]];
        end
      end
      step_d = step_q + 1'b1;
      if (step_q == 4'd13) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    m_q <= m_d;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      res_o[i] = v_q[i] ^ v_q[i+8];
    end
  end

  assign busy_o = busy_q;

endmodule

@@ sim/blake3_256_stream_hasher_core_chk.sv @@
// ----------------------------------------------------------------------------
// blake3_256_stream_hasher_core_chk
// Watches both queue ports of the hasher, keeps its own BLAKE3 model of the
// message state and compares every digest word against the predicted one.
// ----------------------------------------------------------------------------
module blake3_256_stream_hasher_core_chk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  b3sh_pkg::in_item_t  in_item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  b3sh_pkg::out_item_t out_item_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  typedef logic [7:0][31:0]  cv_t;
  typedef logic [15:0][31:0] blk_t;

  cv_t                 hv;
  blk_t                buf_w;
  int unsigned         fill;
  int unsigned         nblk;
  logic [63:0]         chunk_ctr;
  cv_t                 stk [b3sh_pkg::MaxTreeDepth];
  int unsigned         sdepth;
  b3sh_pkg::out_item_t digest_q [$];
  int                  fails = 0;
  int                  pend = 0;

  localparam cv_t IvW = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };
  localparam int Perm [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic cv_t blake_compress(cv_t cv, blk_t blk, logic [63:0] ctr,
                                         logic [31:0] len, logic [31:0] flg);
    logic [31:0] v [16];
    logic [31:0] m [16];
    logic [31:0] t [16];
    int ia [8], ib [8], ic [8], id [8];
    cv_t r;
    ia = '{0, 1, 2, 3, 0, 1, 2, 3};
    ib = '{4, 5, 6, 7, 5, 6, 7, 4};
    ic = '{8, 9, 10, 11, 10, 11, 8, 9};
    id = '{12, 13, 14, 15, 15, 12, 13, 14};
    for (int i = 0; i < 8; i++) begin
      v[i] = cv[i];
      v[i + 8] = IvW[i];
    end
    v[12] = ctr[31:0];
    v[13] = ctr[63:32];
    v[14] = len;
    v[15] = flg;
    for (int i = 0; i < 16; i++) m[i] = blk[i];
    for (int rd = 0; rd < 7; rd++) begin
      for (int g = 0; g < 8; g++) begin
        v[ia[g]] = v[ia[g]] + v[ib[g]] + m[2 * g];
        v[id[g]] = rotr(v[id[g]] ^ v[ia[g]], 16);
        v[ic[g]] = v[ic[g]] + v[id[g]];
        v[ib[g]] = rotr(v[ib[g]] ^ v[ic[g]], 12);
        v[ia[g]] = v[ia[g]] + v[ib[g]] + m[2 * g + 1];
        v[id[g]] = rotr(v[id[g]] ^ v[ia[g]], 8);
        v[ic[g]] = v[ic[g]] + v[id[g]];
        v[ib[g]] = rotr(v[ib[g]] ^ v[ic[g]], 7);
      end
      for (int i = 0; i < 16; i++) t[i] = m[Perm[i]];
      m = t;
    end
    for (int i = 0; i < 8; i++) r[i] = v[i] ^ v[i + 8];
    return r;
  endfunction

  function automatic logic [31:0] sflag();
    return (nblk == 0) ? 32'(b3sh_pkg::FlagStart) : 32'd0;
  endfunction

  task automatic new_chunk(logic [63:0] c);
    hv = IvW;
    buf_w = '0;
    fill = 0;
    nblk = 0;
    chunk_ctr = c;
  endtask

  task automatic push_subtree(cv_t cv, logic [63:0] total);
    blk_t b;
    int   guard;
    guard = 0;
    while (guard < 64 && total[0] == 1'b0 && sdepth > 0) begin
      sdepth--;
      b = {cv, stk[sdepth]};
      cv = blake_compress(IvW, b, 64'd0, 32'(b3sh_pkg::BlockBytes),
                          32'(b3sh_pkg::FlagParent));
      total >>= 1;
      guard++;
    end
    if (sdepth >= b3sh_pkg::MaxTreeDepth) stk[b3sh_pkg::MaxTreeDepth - 1] = cv;
    else begin
      stk[sdepth] = cv;
      sdepth++;
    end
  endtask

  task automatic absorb_word(b3sh_pkg::in_item_t it);
    int unsigned n, pos;
    cv_t         cv;
    cv_t         key, right;
    blk_t        b;
    logic [63:0] ctr;
    logic [31:0] len, flg;
    n = 8;
    if (it.final_item) n = (it.byte_count > 8) ? 8 : it.byte_count;
    if (n > 0) begin
      if (nblk * 64 + fill >= 1024) begin
        cv = blake_compress(hv, buf_w, chunk_ctr, fill,
                            sflag() | 32'(b3sh_pkg::FlagEnd));
        push_subtree(cv, chunk_ctr + 64'd1);
        new_chunk(chunk_ctr + 64'd1);
      end else if (fill >= 64) begin
        hv = blake_compress(hv, buf_w, chunk_ctr, 64, sflag());
        nblk = (nblk + 1) & 15;
        buf_w = '0;
        fill = 0;
      end
      for (int i = 0; i < n; i++) begin
        pos = (fill + i) & 63;
        buf_w[pos >> 2][8 * (pos & 3) +: 8] = it.data_word[8 * i +: 8];
      end
      fill += n;
      if (fill > 64) fill = 64;
    end
    if (!it.final_item) return;
    key = hv;
    b = buf_w;
    ctr = chunk_ctr;
    len = fill;
    flg = sflag() | 32'(b3sh_pkg::FlagEnd);
    for (int s = int'(sdepth) - 1; s >= 0; s--) begin
      right = blake_compress(key, b, ctr, len, flg);
      b = {right, stk[s]};
      key = IvW;
      ctr = 0;
      len = 64;
      flg = 32'(b3sh_pkg::FlagParent);
    end
    cv = blake_compress(key, b, 64'd0, len, flg | 32'(b3sh_pkg::FlagRoot));
    for (int i = 0; i < 4; i++)
      digest_q.push_back('{digest_word: {cv[2 * i + 1], cv[2 * i]}, last_word: (i == 3)});
    new_chunk(0);
    sdepth = 0;
  endtask

  assign fail_cnt_o = fails;
  assign pending_o  = pend;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      new_chunk(0);
      sdepth = 0;
      digest_q.delete();
    end else begin
      if (push_i && !full_i) absorb_word(in_item_i);
      if (pop_i && !empty_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                   out_item_i.digest_word, out_item_i.last_word);
          fails++;
        end else begin
          if (out_item_i !== digest_q[0]) begin
            $display("%0t: digest word expected %h/%b actual %h/%b", $time,
                     digest_q[0].digest_word, digest_q[0].last_word,
                     out_item_i.digest_word, out_item_i.last_word);
            fails++;
          end
          void'(digest_q.pop_front());
        end
      end
    end
    pend = digest_q.size();
  end
endmodule

@@ sim/blake3_256_stream_hasher_core_tb.sv @@
// ----------------------------------------------------------------------------
// blake3_256_stream_hasher_core_tb
// Streams messages of many lengths (empty, partial words, block, chunk and
// multi-chunk sizes) through the hasher with random stalls on both sides.
// ----------------------------------------------------------------------------
module blake3_256_stream_hasher_core_tb;

  logic                clk_i, rst_ni, push, full, empty, pop;
  b3sh_pkg::in_item_t  in_item;
  b3sh_pkg::out_item_t out_item;
  int                  fail_cnt, pending, stall_pct;
  int                  idle_cyc = 0;

  blake3_256_stream_hasher_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_item_i(in_item),
    .empty(empty), .pop(pop), .out_item_o(out_item)
  );

  blake3_256_stream_hasher_core_chk chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .full_i(full), .in_item_i(in_item),
    .empty_i(empty), .pop_i(pop), .out_item_i(out_item), .fail_cnt_o(fail_cnt),
    .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > 20000) begin
      $display("blake3_256_stream_hasher_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) pop <= ($urandom_range(99) >= stall_pct);

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_word(logic [63:0] d, logic [3:0] bc, logic fin);
    while ($urandom_range(99) < stall_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= '{data_word: d, byte_count: bc, final_item: fin};
    // full only moves at the rising edge, so it is stable here
    while (full) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_msg(int nwords, logic [3:0] last_bc, int pattern);
    logic [63:0] d;
    for (int i = 0; i <= nwords; i++) begin
      case (pattern)
        0: d = '0;
        1: d = '1;
        default: d = {$urandom, $urandom};
      endcase
      if (i == nwords) send_word(d, last_bc, 1'b1);
      else send_word(d, 4'($urandom_range(15)), 1'b0);
    end
  endtask

  initial begin
    stall_pct = 27;
    push = 0;
    pop = 0;
    in_item = '0;
    rst_ni = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: empty, short, oversized count, all-zero and all-one data
    send_msg(0, 4'd0, 2);
    send_msg(0, 4'd1, 1);
    send_msg(0, 4'd8, 0);
    send_msg(0, 4'd15, 1);
    send_msg(1, 4'd3, 2);
    send_msg(7, 4'd0, 2);
    send_msg(8, 4'd5, 1);
    // sender holds off until the digest is out
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    stall_pct = 0;
    send_msg(136, 4'd5, 2);
    stall_pct = 27;
    repeat (3) send_msg($urandom_range(20), 4'($urandom_range(15)), 2);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0) $display("blake3_256_stream_hasher_core: match");
    else $display("blake3_256_stream_hasher_core: mismatch");
    $finish;
  end
endmodule

@@ blake3_256_stream_hasher_core.f @@
hw/rtl/b3sh_pkg.sv
hw/rtl/b3sh_ram.sv
hw/rtl/b3sh_in_queue.sv
hw/rtl/b3sh_compress.sv
hw/rtl/blake3_256_stream_hasher_core.sv
sim/blake3_256_stream_hasher_core_chk.sv
sim/blake3_256_stream_hasher_core_tb.sv
